@@ design/tse_pkg.sv @@
// Shared types and constants for the table search engine.
// No dependencies; imported by every module of the block but tse_ram.
package tse_pkg;

   localparam int POS_BITS       = 12;
   localparam int IDX_BITS       = 11;
   localparam int MODE_BITS      = 2;
   localparam int COUNT_BITS     = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int RSP_TDATA_BITS = 32;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // modes 2 and 3 both run the binary search
   localparam logic [MODE_BITS-1:0] MODE_UNSORTED    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LOWER_BOUND = 2'd1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEARCH_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_COUNT = 2'd1;

   localparam logic [MODE_BITS-1:0]  SEARCH_MODE_RESET = 2'd0;
   localparam logic [COUNT_BITS-1:0] TABLE_COUNT_RESET = 12'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_ISSUE,
      ST_SCAN,
      ST_BIN_ISSUE,
      ST_BIN_CMP,
      ST_DONE
   } srch_state_type;

   typedef struct packed {
      logic                found;
      logic [POS_BITS-1:0] position;
      logic [POS_BITS-1:0] probe_count;
   } srch_result_type;

endpackage

@@ design/tse_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tse_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 2048,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tse_search.sv @@
// Search sequencer: drives table reads and one shared key comparator.
// Depends on tse_pkg; reads the table through the RAM's registered read port.
module tse_search #(
   parameter int KEY_BITS  = 20,
   parameter int ADDR_BITS = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [KEY_BITS-1:0]               key,
   input  logic [tse_pkg::MODE_BITS-1:0]     mode,
   input  logic [tse_pkg::COUNT_BITS-1:0]    count,
   input  logic                              out_free,
   input  logic [KEY_BITS-1:0]               rd_data,
   output logic                              rd_en,
   output logic [ADDR_BITS-1:0]              rd_addr,
   output logic                              idle,
   output logic                              done,
   output tse_pkg::srch_result_type          result
);

   import tse_pkg::*;

   srch_state_type        state_ff, state_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [MODE_BITS-1:0]  mode_ff, mode_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic [COUNT_BITS-1:0] lo_ff, lo_in;
   logic [COUNT_BITS-1:0] hi_ff, hi_in;
   logic [COUNT_BITS-1:0] mid_ff, mid_in;
   logic [POS_BITS-1:0]   probe_ff, probe_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  found_ff, found_in;

   logic                  is_lt, is_eq, scan_stop, scan_last, lo_below_hi;
   logic [COUNT_BITS-1:0] idx_next, mid_calc;

   // the one comparator, shared by all modes
   assign is_lt = rd_data < key_ff;
   assign is_eq = rd_data == key_ff;

   always_comb begin
      case (mode_ff)
         MODE_UNSORTED: scan_stop = is_eq;
         default:       scan_stop = !is_lt;
      endcase
   end

   assign idx_next    = idx_ff + 1'b1;
   assign scan_last   = idx_next == count_ff;
   assign lo_below_hi = lo_ff < hi_ff;
   assign mid_calc    = lo_ff + ((hi_ff - 1'b1 - lo_ff) >> 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (mode == MODE_UNSORTED || mode == MODE_LOWER_BOUND) begin
                  state_in = ST_SCAN_ISSUE;
               end else begin
                  state_in = ST_BIN_ISSUE;
               end
            end
         end
         ST_SCAN_ISSUE: begin
            state_in = (count_ff == '0) ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_stop || scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_BIN_ISSUE: begin
            state_in = lo_below_hi ? ST_BIN_CMP : ST_DONE;
         end
         ST_BIN_CMP: begin
            state_in = is_eq ? ST_DONE : ST_BIN_ISSUE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      key_in   = key_ff;
      mode_in  = mode_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      probe_in = probe_ff;
      pos_in   = pos_ff;
      found_in = found_ff;
      rd_en    = 1'b0;
      rd_addr  = ADDR_BITS'(idx_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = key;
               mode_in  = mode;
               count_in = count;
               idx_in   = '0;
               lo_in    = '0;
               hi_in    = count;
               probe_in = '0;
               pos_in   = count;
               found_in = 1'b0;
            end
         end
         ST_SCAN_ISSUE: begin
            rd_en = 1'b1;
         end
         ST_SCAN: begin
            // data in hand is entry idx_ff; next entry is read in the same cycle
            if (scan_stop) begin
               found_in = is_eq;
               pos_in   = is_eq ? idx_ff : count_ff;
               probe_in = idx_ff;
            end else if (scan_last) begin
               probe_in = count_ff;
            end else begin
               idx_in  = idx_next;
               rd_en   = 1'b1;
               rd_addr = ADDR_BITS'(idx_next);
            end
         end
         ST_BIN_ISSUE: begin
            if (lo_below_hi) begin
               mid_in  = mid_calc;
               rd_en   = 1'b1;
               rd_addr = ADDR_BITS'(mid_calc);
            end
         end
         ST_BIN_CMP: begin
            probe_in = probe_ff + 1'b1;
            if (is_eq) begin
               found_in = 1'b1;
               pos_in   = mid_ff;
            end else if (is_lt) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      mode_ff  <= mode_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      probe_ff <= probe_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
   end

   assign idle               = state_ff == ST_IDLE;
   assign done               = state_ff == ST_DONE;
   assign result.found       = found_ff;
   assign result.position    = pos_ff;
   assign result.probe_count = probe_ff;

endmodule

@@ design/table_search_engine.sv @@
// Table search engine top level: stream ports, control registers, key table RAM.
// Depends on tse_pkg, tse_ram and tse_search.
//
// A load word (tuser 0) writes one table entry; loads may follow back to
// back. A search word (tuser 1) looks up the key in the first table_count
// entries and returns one result word. Search time is set by the single
// read port of the key table (registered read) feeding one comparator: a
// scan (modes 0 and 1) reads a new entry every cycle and passes over at
// most table_count entries; a binary search (modes 2 and 3) issues a read
// and then compares, in turn, for each probe.
// The input is not ready while a search runs; a finished result sits in an
// output register, so the next word can be taken while it waits. The table
// has no reset: entries must be loaded before they are searched. Control
// registers are to be written through the csr port only while the block is
// idle; the block itself does not enforce this.
module table_search_engine #(
   parameter int TABLE_DEPTH = 2048,
   parameter int KEY_BITS    = 20,
   localparam int REQ_TDATA_BITS = ((tse_pkg::IDX_BITS + KEY_BITS + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: tdata = {pad, key_value, entry_index}; tuser = cmd
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [REQ_TDATA_BITS-1:0]             req_tdata,
   input  logic                                  req_tuser,
   // response: tdata = {pad, probe_count, position, found}
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tse_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   // control register write
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tse_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tse_pkg::COUNT_BITS-1:0]        csr_data
);

   import tse_pkg::*;

   localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam int RSP_PAD   = RSP_TDATA_BITS - 1 - 2 * POS_BITS;

   logic [MODE_BITS-1:0]  search_mode_ff, search_mode_in;
   logic [COUNT_BITS-1:0] table_count_ff, table_count_in;
   logic [COUNT_BITS-1:0] used_count;

   logic                  rsp_valid_ff, rsp_valid_in;
   srch_result_type       rsp_result_ff, rsp_result_in;

   logic [IDX_BITS-1:0]   entry_index;
   logic [KEY_BITS-1:0]   key_value;
   logic                  req_accept, load_en, start;

   logic                  rd_en, srch_idle, srch_done, out_free;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [KEY_BITS-1:0]   rd_data;
   srch_result_type       srch_result;

   // control registers
   assign csr_ready = 1'b1;

   always_comb begin
      search_mode_in = search_mode_ff;
      table_count_in = table_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SEARCH_MODE: search_mode_in = csr_data[MODE_BITS-1:0];
            CSR_TABLE_COUNT: table_count_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_mode_ff <= SEARCH_MODE_RESET;
         table_count_ff <= TABLE_COUNT_RESET;
      end else begin
         search_mode_ff <= search_mode_in;
         table_count_ff <= table_count_in;
      end
   end

   // counts above the table size are clamped
   assign used_count = (32'(table_count_ff) > TABLE_DEPTH) ? COUNT_BITS'(TABLE_DEPTH)
                                                            : table_count_ff;

   // request side
   assign entry_index = req_tdata[IDX_BITS-1:0];
   assign key_value   = req_tdata[IDX_BITS +: KEY_BITS];
   assign req_tready  = srch_idle;
   assign req_accept  = req_tvalid && req_tready;
   assign load_en     = req_accept && (req_tuser == CMD_LOAD)
                        && (32'(entry_index) < TABLE_DEPTH);
   assign start       = req_accept && (req_tuser == CMD_SEARCH);

   tse_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_key_table (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (ADDR_BITS'(entry_index)),
      .wr_data (key_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tse_search #(
      .KEY_BITS  (KEY_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .key      (key_value),
      .mode     (search_mode_ff),
      .count    (used_count),
      .out_free (out_free),
      .rd_data  (rd_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .idle     (srch_idle),
      .done     (srch_done),
      .result   (srch_result)
   );

   // response register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_result_in = rsp_result_ff;
      if (srch_done && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = srch_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_result_ff.probe_count,
                        rsp_result_ff.position, rsp_result_ff.found};

endmodule

@@ bench/tb_search_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the table search engine bench: a copy of the key table and
// control registers, the expected search results and their check.
// Depends on tse_pkg.
package tb_search_pkg;
   import tse_pkg::*;

   localparam int KEY_BITS       = 20;
   localparam int TABLE_DEPTH    = 2048;
   localparam int REQ_TDATA_BITS = 32;

   // response word layout, lowest bit up
   localparam int RSP_FOUND_BIT = 0;
   localparam int RSP_POS_LSB   = 1;
   localparam int RSP_PROBE_LSB = RSP_POS_LSB + POS_BITS;

   localparam logic [MODE_BITS-1:0] MODE_BINARY     = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_BINARY_ALT = 2'd3;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   class lookup_scoreboard;
      logic [KEY_BITS-1:0]   key_table [TABLE_DEPTH];
      logic [MODE_BITS-1:0]  search_mode;
      logic [COUNT_BITS-1:0] table_count;
      srch_result_type       pending_lookups [$];
      int unsigned           mismatches;
      int unsigned           responses;

      function new();
         search_mode = SEARCH_MODE_RESET;
         table_count = TABLE_COUNT_RESET;
         mismatches  = 0;
         responses   = 0;
         foreach (key_table[i]) key_table[i] = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [COUNT_BITS-1:0] value);
         case (index)
            CSR_SEARCH_MODE: search_mode = value[MODE_BITS-1:0];
            CSR_TABLE_COUNT: table_count = value;
            default: ;
         endcase
      endfunction

      function srch_result_type lookup_key(logic [KEY_BITS-1:0] key);
         srch_result_type r;
         int unsigned n, j, lo, hi, mid;
         bit done;
         n = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : table_count;
         r.found       = 1'b0;
         r.position    = POS_BITS'(n);
         r.probe_count = '0;
         if (search_mode == MODE_UNSORTED) begin
            j = 0;
            while (j < n && key_table[j] != key) j++;
            r.probe_count = POS_BITS'(j);
            if (j < n) begin
               r.found    = 1'b1;
               r.position = POS_BITS'(j);
            end
         end else if (search_mode == MODE_LOWER_BOUND) begin
            j = 0;
            while (j < n && key_table[j] < key) j++;
            r.probe_count = POS_BITS'(j);
            // a stop on a larger entry is a miss, position stays at the count
            if (j < n && key_table[j] == key) begin
               r.found    = 1'b1;
               r.position = POS_BITS'(j);
            end
         end else begin
            lo   = 0;
            hi   = n;
            done = 1'b0;
            while (lo < hi && !done) begin
               mid = lo + ((hi - 1 - lo) >> 1);
               r.probe_count = r.probe_count + 1'b1;
               if (key_table[mid] > key) begin
                  hi = mid;
               end else if (key_table[mid] < key) begin
                  lo = mid + 1;
               end else begin
                  r.found    = 1'b1;
                  r.position = POS_BITS'(mid);
                  done       = 1'b1;
               end
            end
         end
         return r;
      endfunction

      function void note_word(logic cmd, logic [IDX_BITS-1:0] idx,
                              logic [KEY_BITS-1:0] key);
         if (cmd == CMD_LOAD)
            key_table[idx] = key;
         else
            pending_lookups.push_back(lookup_key(key));
      endfunction

      task report_mismatch(string what);
         $display("ERROR at %0t ns: %s", $time, what);
         mismatches++;
      endtask

      task check_response(logic [RSP_TDATA_BITS-1:0] tdata);
         srch_result_type want;
         logic [POS_BITS-1:0] got_pos, got_probes;
         responses++;
         if (pending_lookups.size() == 0) begin
            report_mismatch($sformatf("result word %0d (%h) with no search outstanding",
                                      responses, tdata));
            return;
         end
         want       = pending_lookups.pop_front();
         got_pos    = tdata[RSP_POS_LSB +: POS_BITS];
         got_probes = tdata[RSP_PROBE_LSB +: POS_BITS];
         if (tdata[RSP_FOUND_BIT] !== want.found)
            report_mismatch($sformatf("result %0d: found %b, want %b",
                                      responses, tdata[RSP_FOUND_BIT], want.found));
         if (got_pos !== want.position)
            report_mismatch($sformatf("result %0d: position %0d, want %0d",
                                      responses, got_pos, want.position));
         if (got_probes !== want.probe_count)
            report_mismatch($sformatf("result %0d: probe_count %0d, want %0d",
                                      responses, got_probes, want.probe_count));
      endtask
   endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the table search engine bench: clock, reset, stream and register
// drivers, result monitor, watchdog and the test sequence.
// Depends on tse_pkg, tb_search_pkg and table_search_engine.
module tb_top;
   import tse_pkg::*;
   import tb_search_pkg::*;

   typedef enum int {FLOW_FULL, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_type;

   localparam int unsigned KEY_STRIDE     = 500;
   localparam int unsigned DIRTY_SPAN     = 64;
   localparam int unsigned FILL_TOP       = 64;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned WATCHDOG_LIMIT = 12000;
   localparam int unsigned KEY_MAX        = (1 << KEY_BITS) - 1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [REQ_TDATA_BITS-1:0]     req_tdata = '0;  // entry_index, key_value, pad
   logic                          req_tuser = 1'b0; // cmd
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0]     rsp_tdata;        // found, position, probe_count, pad
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [COUNT_BITS-1:0]         csr_data = '0;

   lookup_scoreboard sb;
   int unsigned sender_idle_pct = 0;
   int unsigned rsp_stall_pct   = 0;
   int unsigned rsp_hold_left   = 0;
   int unsigned rsp_hold_req    = 0;  // hold length asked for by the sequence
   int unsigned rsp_hold_tag    = 0;  // bumped by the sequence for each hold
   int unsigned rsp_hold_seen   = 0;
   int unsigned quiet_cycles    = 0;
   int unsigned dirty_top       = 0;  // entries below this may be out of order

   table_search_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check, then pick tready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
      if (rsp_hold_seen != rsp_hold_tag) begin
         rsp_tready    <= 1'b0;
         rsp_hold_left <= rsp_hold_req;
         rsp_hold_seen <= rsp_hold_tag;
      end else if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_flow(input flow_type flow);
      case (flow)
         FLOW_FULL:           begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
         FLOW_SENDER_IDLE:    begin sender_idle_pct = 77; rsp_stall_pct = 0;  end
         FLOW_RECEIVER_STALL: begin sender_idle_pct = 0;  rsp_stall_pct = 77; end
         default:             begin sender_idle_pct = 15; rsp_stall_pct = 15; end
      endcase
   endtask

   task automatic send_word(input logic cmd, input logic [IDX_BITS-1:0] idx,
                            input logic [KEY_BITS-1:0] key);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_TDATA_BITS - KEY_BITS - IDX_BITS){1'b0}}, key, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_word(cmd, idx, key);
   endtask

   task automatic search(input logic [KEY_BITS-1:0] key);
      send_word(CMD_SEARCH, IDX_BITS'($urandom), key);
   endtask

   // sender holds back until every search has answered, plus loads in flight
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid stays high between writes so it is never dropped and raised
   // in the same step
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [COUNT_BITS-1:0] value, input bit last_write);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(index, value);
      if (last_write) csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [MODE_BITS-1:0] mode, input int unsigned count);
      wait_idle();
      // junk above the mode bits must be dropped
      write_csr(CSR_SEARCH_MODE, {(COUNT_BITS - MODE_BITS)'($urandom), mode}, 1'b0);
      write_csr(CSR_TABLE_COUNT, COUNT_BITS'(count), 1'b1);
   endtask

   // ascending by construction: entry i sits in [i*stride, i*stride + stride - 1], the last in [i*stride, KEY_MAX]
   function automatic logic [KEY_BITS-1:0] sorted_key(input int unsigned i);
      if (i == TABLE_DEPTH - 1)
         return KEY_BITS'($urandom_range(KEY_MAX, KEY_STRIDE * i));
      return KEY_BITS'(KEY_STRIDE * i + $urandom_range(KEY_STRIDE - 1, 0));
   endfunction

   function automatic logic [KEY_BITS-1:0] pick_key(input int unsigned n);
      int unsigned roll;
      logic [KEY_BITS-1:0] k;
      roll = $urandom_range(99);
      k    = sb.key_table[(n == 0) ? 0 : $urandom_range(n - 1, 0)];
      if (roll < 40)
         return k;
      if (roll < 60)
         return $urandom_range(1) ? k + 1'b1 : k - 1'b1;
      if (roll < 75)
         return $urandom_range(1) ? '0 : '1;
      return KEY_BITS'($urandom);
   endfunction

   task automatic run_phase(input logic [MODE_BITS-1:0] mode, input int unsigned count,
                            input flow_type flow, input int unsigned items,
                            input bit restore, input int unsigned hold);
      int unsigned n, lim, idx;
      n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      configure(mode, count);
      set_flow(flow);
      if (restore) begin
         for (int unsigned i = 0; i < dirty_top; i++)
            send_word(CMD_LOAD, IDX_BITS'(i), sorted_key(i));
         dirty_top = 0;
      end
      if (hold > 0) begin
         rsp_hold_req = hold;
         rsp_hold_tag++;
      end
      for (int unsigned i = 0; i < items; i++) begin
         if (flow == FLOW_SENDER_IDLE && i == items / 2)
            wait_idle();
         if ($urandom_range(99) < 30) begin
            if (mode == MODE_UNSORTED) begin
               // scrambled loads stay near the bottom so a reorder is cheap
               lim = (n == 0) ? 1 : ((n < DIRTY_SPAN) ? n : DIRTY_SPAN);
               idx = $urandom_range(lim - 1, 0);
               send_word(CMD_LOAD, IDX_BITS'(idx),
                         $urandom_range(1) ? KEY_BITS'($urandom)
                                           : sb.key_table[$urandom_range(lim - 1, 0)]);
               if (idx >= dirty_top) dirty_top = idx + 1;
            end else begin
               idx = (n == 0) ? 0 : $urandom_range(n - 1, 0);
               send_word(CMD_LOAD, IDX_BITS'(idx), sorted_key(idx));
            end
         end else begin
            search(pick_key(n));
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill the bottom in order, smallest key first, plus the entries that a
      // binary search over the whole table reads on its way to either end
      send_word(CMD_LOAD, '0, '0);
      for (int unsigned i = 1; i < FILL_TOP; i++)
         send_word(CMD_LOAD, IDX_BITS'(i), sorted_key(i));
      for (int unsigned step = TABLE_DEPTH / 2; step > FILL_TOP; step = step / 2)
         send_word(CMD_LOAD, IDX_BITS'(step - 1), sorted_key(step - 1));
      for (int unsigned step = TABLE_DEPTH / 4; step > 0; step = step / 2)
         send_word(CMD_LOAD, IDX_BITS'(TABLE_DEPTH - 1 - step),
                   sorted_key(TABLE_DEPTH - 1 - step));
      send_word(CMD_LOAD, IDX_BITS'(TABLE_DEPTH - 1), '1);

      configure(MODE_UNSORTED, 8);
      search('0);
      search(sb.key_table[7]);
      search('1);
      configure(MODE_LOWER_BOUND, 8);
      search(sb.key_table[3]);
      search(sb.key_table[3] + 1'b1);  // stops on a larger entry
      search('1);                      // runs past the end
      search('0);
      configure(MODE_BINARY, 8);
      search(sb.key_table[5]);
      search(sb.key_table[2] - 1'b1);
      search('1);
      search('0);
      configure(MODE_BINARY_ALT, 8);
      search(sb.key_table[6]);
      search(sb.key_table[6] + 1'b1);
      configure(MODE_UNSORTED, 0);     // empty table
      search('0);
      configure(MODE_BINARY, 1);
      search('0);
      search(KEY_BITS'(5));
      configure(MODE_BINARY, TABLE_DEPTH);
      search('1);
      search('0);
      search(sb.key_table[40]);
      wait_idle();
      write_csr(CSR_SPARE_A, COUNT_BITS'($urandom), 1'b0);
      write_csr(CSR_SPARE_B, COUNT_BITS'($urandom), 1'b1);
      search(sb.key_table[20]);
      configure(MODE_LOWER_BOUND, 4095);  // count clamps to the depth
      search(sb.key_table[60]);
      configure(MODE_UNSORTED, TABLE_DEPTH);
      search(sb.key_table[FILL_TOP - 1]);

      // first phases scramble the bottom and search it in the unsorted, lower-bound and binary modes
      run_phase(MODE_UNSORTED, 24, FLOW_FULL, 16, 1'b0, 0);
      run_phase(MODE_LOWER_BOUND, 20, FLOW_SENDER_IDLE, 12, 1'b0, 0);
      run_phase(MODE_BINARY, 24, FLOW_RECEIVER_STALL, 12, 1'b0, 0);
      run_phase(MODE_LOWER_BOUND, $urandom_range(64, 1), FLOW_BOTH, 12, 1'b1, 0);
      // long receiver hold-off fills the output and blocks the input
      run_phase(MODE_BINARY, $urandom_range(64, 1), FLOW_FULL, 16, 1'b1, 300);
      run_phase(MODE_BINARY_ALT, $urandom_range(64, 1), FLOW_SENDER_IDLE, 12, 1'b1, 0);
      run_phase(MODE_UNSORTED, $urandom_range(64, 1), FLOW_RECEIVER_STALL, 12, 1'b0, 0);
      run_phase(MODE_UNSORTED, $urandom_range(64, 1), FLOW_SENDER_IDLE, 12, 1'b0, 0);
      run_phase(MODE_LOWER_BOUND, $urandom_range(64, 1), FLOW_SENDER_IDLE, 12, 1'b1, 0);
      run_phase(MODE_BINARY, $urandom_range(64, 1), FLOW_BOTH, 12, 1'b1, 0);

      wait_idle();
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
